[sv/pngcp_pkg.sv]
// Shared constants, codes and helper functions for the PNG container parser.
package pngcp_pkg;

  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  // Result kinds
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Error codes, lower code wins among header faults
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_EARLY_END = 4'd1;
  localparam logic [3:0] ERR_SIG       = 4'd2;
  localparam logic [3:0] ERR_NOT_IHDR  = 4'd3;
  localparam logic [3:0] ERR_IHDR_LEN  = 4'd4;
  localparam logic [3:0] ERR_IHDR_CRC  = 4'd5;
  localparam logic [3:0] ERR_METHODS   = 4'd6;
  localparam logic [3:0] ERR_DEPTH     = 4'd7;
  localparam logic [3:0] ERR_COLOUR    = 4'd8;
  localparam logic [3:0] ERR_NOT_IDAT  = 4'd9;
  localparam logic [3:0] ERR_IDAT_CRC  = 4'd10;
  localparam logic [3:0] ERR_IEND      = 4'd11;

  localparam logic [7:0] SIG_BYTES [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                           8'h0D, 8'h0A, 8'h1A, 8'h0A};
  localparam logic [7:0] IHDR_LEN_BYTES  [4] = '{8'h00, 8'h00, 8'h00, 8'd13};
  localparam logic [7:0] IHDR_TYPE_BYTES [4] = '{8'h49, 8'h48, 8'h44, 8'h52};
  localparam logic [7:0] IDAT_TYPE_BYTES [4] = '{8'h49, 8'h44, 8'h41, 8'h54};
  localparam logic [7:0] IEND_TRAILER [12] = '{8'h00, 8'h00, 8'h00, 8'h00,
                                               8'h49, 8'h45, 8'h4E, 8'h44,
                                               8'hAE, 8'h42, 8'h60, 8'h82};

  localparam logic [7:0] DepthNarrow = 8'd8;
  localparam logic [7:0] DepthWide   = 8'd16;

  // Reflected CRC-32, one byte per call
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic [2:0] channels_of(input logic [7:0] colour);
    logic [2:0] n;
    case (colour)
      8'd0:    n = 3'd1;
      8'd4:    n = 3'd2;
      8'd2:    n = 3'd3;
      8'd6:    n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Keep the lowest nonzero fault code
  function automatic logic [3:0] merge_fault(input logic [3:0] pend, input logic [3:0] code);
    logic [3:0] r;
    r = pend;
    if (pend == ERR_NONE || code < pend) begin
      r = code;
    end
    return r;
  endfunction

endpackage

[sv/png_container_parser_core.sv]
// Byte-serial PNG container checker that streams out the IDAT payload.
//
// Input stream: one word per file byte on s_axis (tdata = byte, tlast marks
// the final byte of the file). Output stream: exactly one word per input
// word on m_axis; tuser carries the kind (nothing, payload byte, file
// accepted, error) and tdata the payload byte, IHDR values and error code.
// The block checks the signature and IHDR (reported on the 33rd byte),
// forwards IDAT payload bytes as they arrive, checks the IDAT CRC-32 and
// requires an exact IEND chunk as the last bytes of the file.
// The result of a byte sits in the output register on the cycle after the
// byte is taken. One byte per cycle while the receiver takes results, set
// by the byte-wide CRC-32 update between the input and the result register.
// Payload leaves before the IDAT CRC is confirmed; downstream drops it when
// the file ends in an error. After an error on a byte that is not the last,
// later bytes give kind nothing until a byte marked last.
// Reset (rst_ni low) empties the output register and starts at the
// signature. When the receiver stalls, the result waits in the output
// register and s_axis_tready_o drops until it is taken; a result taken in
// the same cycle frees the register for the next byte.
module png_container_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] payload_byte, [39:8] image_width, [71:40] image_height,
  // [74:72] channel_count, [75] wide_samples, [79:76] error_code
  output logic [79:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o    // [1:0] kind
);

  typedef enum logic [2:0] {
    PH_HEAD,
    PH_IDLEN,
    PH_IDTYPE,
    PH_IDDATA,
    PH_IDCRC,
    PH_IEND,
    PH_DRAIN
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] bc_q, bc_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic        wide_q, wide_d;
  logic [2:0]  chan_q, chan_d;
  logic [31:0] plen_q, plen_d;
  logic [31:0] rcrc_q, rcrc_d;
  logic [3:0]  pend_q, pend_d;

  logic        out_valid_q;
  logic [79:0] out_data_q, out_data_d;
  logic [1:0]  out_kind_q, out_kind_d;

  logic        in_acc;
  logic [7:0]  b;
  logic        last;
  logic [31:0] bc_inc;
  logic        known;
  logic        finished;
  logic [7:0]  pay;
  logic [3:0]  err;

  // Take a new byte whenever the output register is empty or being drained
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign b               = s_axis_tdata_i;
  assign last            = s_axis_tlast_i;
  assign bc_inc          = bc_q + 32'd1;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;

  always_comb begin
    phase_d    = phase_q;
    bc_d       = bc_q;
    crc_d      = crc_q;
    width_d    = width_q;
    height_d   = height_q;
    wide_d     = wide_q;
    chan_d     = chan_q;
    plen_d     = plen_q;
    rcrc_d     = rcrc_q;
    pend_d     = pend_q;
    out_kind_d = pngcp_pkg::KIND_NONE;
    pay        = 8'd0;
    err        = pngcp_pkg::ERR_NONE;
    finished   = 1'b0;
    known      = (phase_q == PH_IDLEN) || (phase_q == PH_IDTYPE) ||
                 (phase_q == PH_IDDATA) || (phase_q == PH_IDCRC) ||
                 (phase_q == PH_IEND);

    case (phase_q)
      PH_HEAD: begin
        if (bc_q < 32'd8) begin
          if (b != pngcp_pkg::SIG_BYTES[bc_q[2:0]])
            pend_d = pngcp_pkg::merge_fault(pend_d, pngcp_pkg::ERR_SIG);
        end else if (bc_q < 32'd12) begin
          if (b != pngcp_pkg::IHDR_LEN_BYTES[bc_q[1:0]])
            pend_d = pngcp_pkg::merge_fault(pend_d, pngcp_pkg::ERR_IHDR_LEN);
        end else if (bc_q < 32'd16) begin
          if (b != pngcp_pkg::IHDR_TYPE_BYTES[bc_q[1:0]])
            pend_d = pngcp_pkg::merge_fault(pend_d, pngcp_pkg::ERR_NOT_IHDR);
        end else if (bc_q < 32'd20) begin
          width_d = {width_q[23:0], b};
        end else if (bc_q < 32'd24) begin
          height_d = {height_q[23:0], b};
        end else if (bc_q == 32'd24) begin
          wide_d = (b == pngcp_pkg::DepthWide);
          if (b != pngcp_pkg::DepthNarrow && b != pngcp_pkg::DepthWide)
            pend_d = pngcp_pkg::merge_fault(pend_d, pngcp_pkg::ERR_DEPTH);
        end else if (bc_q == 32'd25) begin
          chan_d = pngcp_pkg::channels_of(b);
          if (pngcp_pkg::channels_of(b) == 3'd0)
            pend_d = pngcp_pkg::merge_fault(pend_d, pngcp_pkg::ERR_COLOUR);
        end else if (bc_q < 32'd29) begin
          if (b != 8'd0)
            pend_d = pngcp_pkg::merge_fault(pend_d, pngcp_pkg::ERR_METHODS);
        end else begin
          rcrc_d = {rcrc_q[23:0], b};
        end
        // CRC covers chunk type and the 13 data bytes
        if (bc_q >= 32'd12 && bc_q <= 32'd28) crc_d = pngcp_pkg::crc_byte(crc_q, b);
        if (bc_q >= 32'd32) begin
          if ((crc_q ^ pngcp_pkg::CrcInit) != rcrc_d)
            pend_d = pngcp_pkg::merge_fault(pend_d, pngcp_pkg::ERR_IHDR_CRC);
          if (pend_d != pngcp_pkg::ERR_NONE) begin
            out_kind_d = pngcp_pkg::KIND_ERROR;
            err        = pend_d;
            finished   = 1'b1;
          end else if (last) begin
            out_kind_d = pngcp_pkg::KIND_ERROR;
            err        = pngcp_pkg::ERR_EARLY_END;
            finished   = 1'b1;
          end else begin
            known   = 1'b1;
            phase_d = PH_IDLEN;
            bc_d    = 32'd0;
            crc_d   = pngcp_pkg::CrcInit;
            rcrc_d  = 32'd0;
            plen_d  = 32'd0;
          end
        end else if (last) begin
          out_kind_d = pngcp_pkg::KIND_ERROR;
          err        = pngcp_pkg::ERR_EARLY_END;
          finished   = 1'b1;
        end else begin
          bc_d = bc_inc;
        end
      end
      PH_IDLEN: begin
        plen_d = {plen_q[23:0], b};
        if (last) begin
          out_kind_d = pngcp_pkg::KIND_ERROR;
          err        = pngcp_pkg::ERR_EARLY_END;
          finished   = 1'b1;
        end else if (bc_q >= 32'd3) begin
          phase_d = PH_IDTYPE;
          bc_d    = 32'd0;
          crc_d   = pngcp_pkg::CrcInit;
        end else begin
          bc_d = bc_inc;
        end
      end
      PH_IDTYPE: begin
        crc_d = pngcp_pkg::crc_byte(crc_q, b);
        if (b != pngcp_pkg::IDAT_TYPE_BYTES[bc_q[1:0]])
          pend_d = pngcp_pkg::merge_fault(pend_d, pngcp_pkg::ERR_NOT_IDAT);
        if (bc_q >= 32'd3) begin
          if (pend_d != pngcp_pkg::ERR_NONE) begin
            out_kind_d = pngcp_pkg::KIND_ERROR;
            err        = pend_d;
            finished   = 1'b1;
          end else if (last) begin
            out_kind_d = pngcp_pkg::KIND_ERROR;
            err        = pngcp_pkg::ERR_EARLY_END;
            finished   = 1'b1;
          end else begin
            phase_d = (plen_q == 32'd0) ? PH_IDCRC : PH_IDDATA;
            bc_d    = 32'd0;
          end
        end else if (last) begin
          out_kind_d = pngcp_pkg::KIND_ERROR;
          err        = pngcp_pkg::ERR_EARLY_END;
          finished   = 1'b1;
        end else begin
          bc_d = bc_inc;
        end
      end
      PH_IDDATA: begin
        crc_d = pngcp_pkg::crc_byte(crc_q, b);
        if (last) begin
          out_kind_d = pngcp_pkg::KIND_ERROR;
          err        = pngcp_pkg::ERR_EARLY_END;
          finished   = 1'b1;
        end else begin
          out_kind_d = pngcp_pkg::KIND_PAYLOAD;
          pay        = b;
          bc_d       = bc_inc;
          if (bc_inc == plen_q) begin
            phase_d = PH_IDCRC;
            bc_d    = 32'd0;
          end
        end
      end
      PH_IDCRC: begin
        rcrc_d = {rcrc_q[23:0], b};
        if (bc_q >= 32'd3) begin
          if ((crc_q ^ pngcp_pkg::CrcInit) != rcrc_d) begin
            out_kind_d = pngcp_pkg::KIND_ERROR;
            err        = pngcp_pkg::ERR_IDAT_CRC;
            finished   = 1'b1;
          end else if (last) begin
            out_kind_d = pngcp_pkg::KIND_ERROR;
            err        = pngcp_pkg::ERR_IEND;
            finished   = 1'b1;
          end else begin
            phase_d = PH_IEND;
            bc_d    = 32'd0;
          end
        end else if (last) begin
          out_kind_d = pngcp_pkg::KIND_ERROR;
          err        = pngcp_pkg::ERR_EARLY_END;
          finished   = 1'b1;
        end else begin
          bc_d = bc_inc;
        end
      end
      PH_IEND: begin
        if (bc_q > 32'd11 || b != pngcp_pkg::IEND_TRAILER[bc_q[3:0]])
          pend_d = pngcp_pkg::merge_fault(pend_d, pngcp_pkg::ERR_IEND);
        if (bc_q >= 32'd11) begin
          finished = 1'b1;
          if (pend_d != pngcp_pkg::ERR_NONE || !last) begin
            out_kind_d = pngcp_pkg::KIND_ERROR;
            err        = pngcp_pkg::ERR_IEND;
          end else begin
            out_kind_d = pngcp_pkg::KIND_DONE;
          end
        end else if (last) begin
          out_kind_d = pngcp_pkg::KIND_ERROR;
          err        = pngcp_pkg::ERR_IEND;
          finished   = 1'b1;
        end else begin
          bc_d = bc_inc;
        end
      end
      default: begin
        // Drain: swallow bytes until the end of the file
        if (last) finished = 1'b1;
      end
    endcase

    // Result word is built from the updated header values
    out_data_d = {err,
                  known ? wide_d : 1'b0,
                  known ? chan_d : 3'd0,
                  known ? height_d : 32'd0,
                  known ? width_d : 32'd0,
                  pay};

    // End of a file restarts at the signature, an early error drains
    if (finished) begin
      if (last) begin
        phase_d  = PH_HEAD;
        bc_d     = 32'd0;
        crc_d    = pngcp_pkg::CrcInit;
        width_d  = 32'd0;
        height_d = 32'd0;
        wide_d   = 1'b0;
        chan_d   = 3'd0;
        plen_d   = 32'd0;
        rcrc_d   = 32'd0;
        pend_d   = pngcp_pkg::ERR_NONE;
      end else begin
        phase_d = PH_DRAIN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEAD;
      bc_q        <= 32'd0;
      crc_q       <= pngcp_pkg::CrcInit;
      width_q     <= 32'd0;
      height_q    <= 32'd0;
      wide_q      <= 1'b0;
      chan_q      <= 3'd0;
      plen_q      <= 32'd0;
      rcrc_q      <= 32'd0;
      pend_q      <= pngcp_pkg::ERR_NONE;
      out_valid_q <= 1'b0;
      out_kind_q  <= pngcp_pkg::KIND_NONE;
      out_data_q  <= '0;
    end else if (in_acc) begin
      phase_q     <= phase_d;
      bc_q        <= bc_d;
      crc_q       <= crc_d;
      width_q     <= width_d;
      height_q    <= height_d;
      wide_q      <= wide_d;
      chan_q      <= chan_d;
      plen_q      <= plen_d;
      rcrc_q      <= rcrc_d;
      pend_q      <= pend_d;
      out_valid_q <= 1'b1;
      out_kind_q  <= out_kind_d;
      out_data_q  <= out_data_d;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule
